// ===== hw/rtl/erv3_pkg.sv =====
// ----------------------------------------------------------------------------
// erv3_pkg
// Shared types, widths, register indexes and tables for the Euler rotation
// block: coordinate and coefficient types, the CORDIC arctangent table and the
// micro-program that turns sines and cosines into matrix coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

package erv3_pkg;

    // Field and arithmetic widths
    localparam int ANGLE_BITS      = 16;
    localparam int COORD_BITS      = 18;
    localparam int COEF_FRAC_BITS  = 16;
    localparam int TRIG_ITERATIONS = 16;

    localparam int COEF_W    = COEF_FRAC_BITS + 2;
    localparam int OUT_W     = COORD_BITS + 1;
    localparam int TRIG_FRAC = 30;
    localparam int TRIG_W    = 32;
    localparam int TURN_W    = 32;
    localparam int ACC_W     = 2 * TRIG_W + 1;

    // CORDIC
    localparam int ATAN_COUNT   = 24;
    localparam int ATAN_IDX_W   = 5;
    localparam int CORDIC_STEPS = (TRIG_ITERATIONS < ATAN_COUNT) ? TRIG_ITERATIONS
                                                                  : ATAN_COUNT;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032875);
    localparam logic signed [TRIG_W-1:0] TRIG_ONE    = TRIG_W'(1) << TRIG_FRAC;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_YAW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL  = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [OUT_W-1:0]      ocoord_t;
    typedef logic signed [COEF_W-1:0]     coef_t;
    typedef coef_t [8:0]                  matrix_t;
    typedef logic signed [TRIG_W-1:0]     trig_t;
    typedef trig_t [5:0]                  trig_set_t;

    // Rebuild unit status seen by the top level
    typedef struct packed {
        logic pending;
        logic running;
    } rb_status_t;

    // Micro-program operand codes
    localparam int OPND_W = 4;
    localparam logic [OPND_W-1:0] OPND_CA   = 4'd0;
    localparam logic [OPND_W-1:0] OPND_SA   = 4'd1;
    localparam logic [OPND_W-1:0] OPND_CB   = 4'd2;
    localparam logic [OPND_W-1:0] OPND_SB   = 4'd3;
    localparam logic [OPND_W-1:0] OPND_CG   = 4'd4;
    localparam logic [OPND_W-1:0] OPND_SG   = 4'd5;
    localparam logic [OPND_W-1:0] OPND_CASB = 4'd6;
    localparam logic [OPND_W-1:0] OPND_SASB = 4'd7;
    localparam logic [OPND_W-1:0] OPND_ONE  = 4'd8;

    // Accumulator operations
    localparam logic [1:0] ACC_LOAD = 2'd0;
    localparam logic [1:0] ACC_ADD  = 2'd1;
    localparam logic [1:0] ACC_SUB  = 2'd2;
    localparam logic [1:0] ACC_NEG  = 2'd3;

    // Result destinations
    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_CASB = 2'd1;
    localparam logic [1:0] WR_SASB = 2'd2;
    localparam logic [1:0] WR_COEF = 2'd3;

    typedef struct packed {
        logic [OPND_W-1:0] opnd_a;
        logic [OPND_W-1:0] opnd_b;
        logic [1:0]        acc_op;
        logic [1:0]        wr_kind;
        logic [3:0]        wr_idx;
    } uop_t;

    localparam int UOP_COUNT = 15;
    localparam int STEP_W    = $clog2(UOP_COUNT);

    // Arctangent of 2^-i in 32-bit turn units
    function automatic trig_t atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        trig_t a;
        begin
            unique case (idx)
                5'd0:    a = 32'h20000000;
                5'd1:    a = 32'h12E4051E;
                5'd2:    a = 32'h09FB385B;
                5'd3:    a = 32'h051111D4;
                5'd4:    a = 32'h028B0D43;
                5'd5:    a = 32'h0145D7E1;
                5'd6:    a = 32'h00A2F61E;
                5'd7:    a = 32'h00517C55;
                5'd8:    a = 32'h0028BE53;
                5'd9:    a = 32'h00145F2F;
                5'd10:   a = 32'h000A2F98;
                5'd11:   a = 32'h000517CC;
                5'd12:   a = 32'h00028BE6;
                5'd13:   a = 32'h000145F3;
                5'd14:   a = 32'h0000A2F9;
                5'd15:   a = 32'h0000517C;
                5'd16:   a = 32'h000028BE;
                5'd17:   a = 32'h0000145F;
                5'd18:   a = 32'h00000A2F;
                5'd19:   a = 32'h00000517;
                5'd20:   a = 32'h0000028B;
                5'd21:   a = 32'h00000145;
                5'd22:   a = 32'h000000A2;
                5'd23:   a = 32'h00000051;
                default: a = '0;
            endcase
            return a;
        end
    endfunction

    // Products and sums that build the matrix, one product per step
    function automatic uop_t uop(input logic [STEP_W-1:0] step);
        uop_t u;
        begin
            unique case (step)
                4'd0:    u = '{OPND_CA,   OPND_SB,  ACC_LOAD, WR_CASB, 4'd0};
                4'd1:    u = '{OPND_SA,   OPND_SB,  ACC_LOAD, WR_SASB, 4'd0};
                4'd2:    u = '{OPND_CA,   OPND_CB,  ACC_LOAD, WR_COEF, 4'd0};
                4'd3:    u = '{OPND_CASB, OPND_SG,  ACC_LOAD, WR_NONE, 4'd0};
                4'd4:    u = '{OPND_SA,   OPND_CG,  ACC_SUB,  WR_COEF, 4'd1};
                4'd5:    u = '{OPND_CASB, OPND_CG,  ACC_LOAD, WR_NONE, 4'd0};
                4'd6:    u = '{OPND_SA,   OPND_SG,  ACC_ADD,  WR_COEF, 4'd2};
                4'd7:    u = '{OPND_SA,   OPND_CB,  ACC_LOAD, WR_COEF, 4'd3};
                4'd8:    u = '{OPND_SASB, OPND_SG,  ACC_LOAD, WR_NONE, 4'd0};
                4'd9:    u = '{OPND_CA,   OPND_CG,  ACC_ADD,  WR_COEF, 4'd4};
                4'd10:   u = '{OPND_SASB, OPND_CG,  ACC_LOAD, WR_NONE, 4'd0};
                4'd11:   u = '{OPND_CA,   OPND_SG,  ACC_SUB,  WR_COEF, 4'd5};
                4'd12:   u = '{OPND_SB,   OPND_ONE, ACC_NEG,  WR_COEF, 4'd6};
                4'd13:   u = '{OPND_CB,   OPND_SG,  ACC_LOAD, WR_COEF, 4'd7};
                4'd14:   u = '{OPND_CB,   OPND_CG,  ACC_LOAD, WR_COEF, 4'd8};
                default: u = '{OPND_ONE,  OPND_ONE, ACC_LOAD, WR_NONE, 4'd0};
            endcase
            return u;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/erv3_rebuild.sv =====
// ----------------------------------------------------------------------------
// erv3_rebuild
// Angle registers and matrix builder. An angle register write marks the matrix stale;
// a shared CORDIC then yields the three sine/cosine pairs, and one 32x32
// multiplier with an accumulator forms the nine Q1.16 coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module erv3_rebuild
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [erv3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [erv3_pkg::ANGLE_BITS-1:0]   cfg_data,
    output      erv3_pkg::matrix_t                 matrix,
    output      erv3_pkg::rb_status_t              status
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ITER  = 3'd2;
    localparam logic [2:0] ST_STORE = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_ACC   = 3'd5;
    localparam logic [2:0] ST_WRITE = 3'd6;

    // Angle being converted
    localparam logic [1:0] ANG_ROLL  = 2'd0;
    localparam logic [1:0] ANG_PITCH = 2'd1;
    localparam logic [1:0] ANG_YAW   = 2'd2;

    localparam int TRIG_W     = erv3_pkg::TRIG_W;
    localparam int ACC_W      = erv3_pkg::ACC_W;
    localparam int PROD_W     = 2 * TRIG_W;
    localparam int COEF_SHIFT = 2 * erv3_pkg::TRIG_FRAC - erv3_pkg::COEF_FRAC_BITS;
    localparam int COEF_W     = erv3_pkg::COEF_W;

    localparam logic signed [ACC_W-1:0] Q30_HALF  = ACC_W'(1) <<< (erv3_pkg::TRIG_FRAC - 1);
    localparam logic signed [ACC_W-1:0] COEF_HALF = ACC_W'(1) <<< (COEF_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI    = ACC_W'((2 ** (COEF_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO    = -SAT_HI - ACC_W'(1);
    localparam logic [erv3_pkg::ITER_W-1:0] ITER_LAST =
        erv3_pkg::ITER_W'(erv3_pkg::CORDIC_STEPS - 1);
    localparam logic [erv3_pkg::STEP_W-1:0] STEP_LAST =
        erv3_pkg::STEP_W'(erv3_pkg::UOP_COUNT - 1);
    localparam erv3_pkg::coef_t COEF_ONE = erv3_pkg::coef_t'(1) <<< erv3_pkg::COEF_FRAC_BITS;

    logic [erv3_pkg::ANGLE_BITS-1:0] yaw_reg, pitch_reg, roll_reg;
    logic                            pending_reg, pending_next;
    logic [2:0]                      state_reg, state_next;
    logic [1:0]                      ang_sel_reg;
    logic [erv3_pkg::ITER_W-1:0]     iter_reg;
    logic [erv3_pkg::STEP_W-1:0]     step_reg;
    logic [1:0]                      quad_reg;
    logic signed [TRIG_W-1:0]        x_reg, y_reg, z_reg;
    logic signed [TRIG_W-1:0]        x_next, y_next, z_next;
    erv3_pkg::trig_set_t             trig_reg;
    logic signed [TRIG_W-1:0]        casb_reg, sasb_reg;
    logic signed [PROD_W-1:0]        prod_reg;
    logic signed [ACC_W-1:0]         acc_reg, acc_next;
    erv3_pkg::matrix_t               matrix_reg;

    logic                            cfg_write;
    logic                            cfg_hit;
    logic [erv3_pkg::ANGLE_BITS-1:0] angle_sel;
    logic [erv3_pkg::TURN_W-1:0]     turn;
    logic signed [TRIG_W-1:0]        dx, dy, atan_val;
    logic signed [TRIG_W-1:0]        cos_q, sin_q;
    logic signed [TRIG_W-1:0]        opnd_a, opnd_b;
    logic signed [PROD_W-1:0]        ext_prod;
    logic signed [ACC_W-1:0]         q30_rnd, coef_rnd, coef_sh;
    logic signed [TRIG_W-1:0]        q30_val;
    erv3_pkg::coef_t                 coef_val;
    erv3_pkg::uop_t                  cur_uop;
    logic [2:0]                      trig_idx;

    // Operand select for the shared multiplier
    function automatic logic signed [TRIG_W-1:0] pick(
        input logic [erv3_pkg::OPND_W-1:0] code,
        input erv3_pkg::trig_set_t         trig,
        input logic signed [TRIG_W-1:0]    casb,
        input logic signed [TRIG_W-1:0]    sasb
    );
        logic signed [TRIG_W-1:0] v;
        begin
            unique case (code)
                erv3_pkg::OPND_CA:   v = trig[0];
                erv3_pkg::OPND_SA:   v = trig[1];
                erv3_pkg::OPND_CB:   v = trig[2];
                erv3_pkg::OPND_SB:   v = trig[3];
                erv3_pkg::OPND_CG:   v = trig[4];
                erv3_pkg::OPND_SG:   v = trig[5];
                erv3_pkg::OPND_CASB: v = casb;
                erv3_pkg::OPND_SASB: v = sasb;
                default:             v = erv3_pkg::TRIG_ONE;
            endcase
            return v;
        end
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_hit   = (cfg_index == erv3_pkg::REG_YAW) || (cfg_index == erv3_pkg::REG_PITCH)
                    || (cfg_index == erv3_pkg::REG_ROLL);

    assign matrix         = matrix_reg;
    assign status.pending = pending_reg;
    assign status.running = (state_reg != ST_IDLE);

    // Angle registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_reg   <= '0;
            pitch_reg <= '0;
            roll_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                erv3_pkg::REG_YAW:   yaw_reg   <= cfg_data;
                erv3_pkg::REG_PITCH: pitch_reg <= cfg_data;
                erv3_pkg::REG_ROLL:  roll_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Angle for the current CORDIC pass, scaled to a 32-bit turn
    always_comb
    begin
        unique case (ang_sel_reg)
            ANG_PITCH: angle_sel = pitch_reg;
            ANG_YAW:   angle_sel = yaw_reg;
            default:   angle_sel = roll_reg;
        endcase
        turn = erv3_pkg::TURN_W'(angle_sel) << (erv3_pkg::TURN_W - erv3_pkg::ANGLE_BITS);
    end

    // One CORDIC rotation step
    always_comb
    begin
        dx       = y_reg >>> iter_reg;
        dy       = x_reg >>> iter_reg;
        atan_val = erv3_pkg::atan_turn(erv3_pkg::ATAN_IDX_W'(iter_reg));
        if (!z_reg[TRIG_W-1])
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - atan_val;
        end
        else
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + atan_val;
        end
    end

    // Quadrant fold of the CORDIC result
    always_comb
    begin
        unique case (quad_reg)
            2'd0:    begin cos_q = x_reg;  sin_q = y_reg;  end
            2'd1:    begin cos_q = -y_reg; sin_q = x_reg;  end
            2'd2:    begin cos_q = -x_reg; sin_q = -y_reg; end
            default: begin cos_q = y_reg;  sin_q = -x_reg; end
        endcase
        trig_idx = {1'b0, ang_sel_reg} << 1;
    end

    // Multiply-accumulate and rounding
    always_comb
    begin
        cur_uop  = erv3_pkg::uop(step_reg);
        opnd_a   = pick(cur_uop.opnd_a, trig_reg, casb_reg, sasb_reg);
        opnd_b   = pick(cur_uop.opnd_b, trig_reg, casb_reg, sasb_reg);
        ext_prod = prod_reg;
        unique case (cur_uop.acc_op)
            erv3_pkg::ACC_ADD: acc_next = acc_reg + {ext_prod[PROD_W-1], ext_prod};
            erv3_pkg::ACC_SUB: acc_next = acc_reg - {ext_prod[PROD_W-1], ext_prod};
            erv3_pkg::ACC_NEG: acc_next = -{ext_prod[PROD_W-1], ext_prod};
            default:           acc_next = {ext_prod[PROD_W-1], ext_prod};
        endcase

        q30_rnd  = (acc_reg + Q30_HALF) >>> erv3_pkg::TRIG_FRAC;
        q30_val  = q30_rnd[TRIG_W-1:0];
        coef_rnd = acc_reg + COEF_HALF;
        coef_sh  = coef_rnd >>> COEF_SHIFT;
        if (coef_sh > SAT_HI)
            coef_val = SAT_HI[COEF_W-1:0];
        else if (coef_sh < SAT_LO)
            coef_val = SAT_LO[COEF_W-1:0];
        else
            coef_val = coef_sh[COEF_W-1:0];
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pending_reg)
                begin
                    pending_next = 1'b0;
                    state_next   = ST_LOAD;
                end
            end
            ST_LOAD:  state_next = ST_ITER;
            ST_ITER:
            begin
                if (iter_reg == ITER_LAST)
                    state_next = ST_STORE;
            end
            ST_STORE: state_next = (ang_sel_reg == ANG_YAW) ? ST_MUL : ST_LOAD;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:
            begin
                if (cur_uop.wr_kind != erv3_pkg::WR_NONE)
                    state_next = ST_WRITE;
                else
                    state_next = ST_MUL;
            end
            ST_WRITE: state_next = (step_reg == STEP_LAST) ? ST_IDLE : ST_MUL;
            default:  state_next = ST_IDLE;
        endcase
        // a write to an angle register marks a new build pending
        if (cfg_write && cfg_hit)
            pending_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
            ang_sel_reg <= ANG_ROLL;
            iter_reg    <= '0;
            step_reg    <= '0;
            for (int k = 0; k < 9; k++)
                matrix_reg[k] <= (k % 4 == 0) ? COEF_ONE : '0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    ang_sel_reg <= ANG_ROLL;
                    step_reg    <= '0;
                end
                ST_LOAD:  iter_reg <= '0;
                ST_ITER:  iter_reg <= iter_reg + 1'b1;
                ST_STORE: ang_sel_reg <= ang_sel_reg + 1'b1;
                ST_ACC:
                begin
                    if (cur_uop.wr_kind == erv3_pkg::WR_NONE)
                        step_reg <= step_reg + 1'b1;
                end
                ST_WRITE:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (cur_uop.wr_kind == erv3_pkg::WR_COEF)
                        matrix_reg[cur_uop.wr_idx] <= coef_val;
                end
                default: ;
            endcase
        end
    end

    // CORDIC and multiplier datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_LOAD:
            begin
                x_reg    <= erv3_pkg::CORDIC_GAIN;
                y_reg    <= '0;
                z_reg    <= {2'b00, turn[erv3_pkg::TURN_W-3:0]};
                quad_reg <= turn[erv3_pkg::TURN_W-1 -: 2];
            end
            ST_ITER:
            begin
                x_reg <= x_next;
                y_reg <= y_next;
                z_reg <= z_next;
            end
            ST_STORE:
            begin
                trig_reg[trig_idx]        <= cos_q;
                trig_reg[trig_idx + 3'd1] <= sin_q;
            end
            ST_MUL:   prod_reg <= opnd_a * opnd_b;
            ST_ACC:   acc_reg  <= acc_next;
            ST_WRITE:
            begin
                if (cur_uop.wr_kind == erv3_pkg::WR_CASB)
                    casb_reg <= q30_val;
                if (cur_uop.wr_kind == erv3_pkg::WR_SASB)
                    sasb_reg <= q30_val;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/erv3_rotate.sv =====
// ----------------------------------------------------------------------------
// erv3_rotate
// Four-stage matrix-vector pipeline: input register, nine products, row sums,
// then rounding and saturation into the output register. Valid bits travel
// with the data and each stage holds while the stage after it is full and cannot drain.
// ----------------------------------------------------------------------------
`default_nettype none

module erv3_rotate
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire erv3_pkg::coord_t  x_in,
    input  wire erv3_pkg::coord_t  y_in,
    input  wire erv3_pkg::coord_t  z_in,
    input  wire erv3_pkg::matrix_t matrix,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      erv3_pkg::ocoord_t x_out,
    output      erv3_pkg::ocoord_t y_out,
    output      erv3_pkg::ocoord_t z_out
);

    localparam int CW     = erv3_pkg::COORD_BITS;
    localparam int PROD_W = erv3_pkg::COEF_W + CW;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RND_W  = SUM_W - erv3_pkg::COEF_FRAC_BITS;
    localparam int OUT_W  = erv3_pkg::OUT_W;

    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (erv3_pkg::COEF_FRAC_BITS - 1);
    localparam logic signed [RND_W-1:0] SAT_HI   = RND_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [RND_W-1:0] SAT_LO   = -SAT_HI - RND_W'(1);

    logic                      v0_reg, v1_reg, v2_reg, v3_reg;
    logic                      rdy0, rdy1, rdy2, rdy3;
    logic signed [CW-1:0]      vec_reg [3];
    logic signed [PROD_W-1:0]  prod_reg [9];
    logic signed [SUM_W-1:0]   sum_reg [3];
    logic signed [OUT_W-1:0]   res_reg [3];
    logic signed [PROD_W-1:0]  prod_c [9];
    logic signed [SUM_W-1:0]   sum_c [3];
    logic signed [RND_W-1:0]   rnd_c [3];
    logic signed [OUT_W-1:0]   res_c [3];
    logic signed [SUM_W-1:0]   rsum;

    // Stage handshake: a stage takes new data when it is empty or drains
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_ready = rdy0;

    assign out_valid = v3_reg;
    assign x_out     = res_reg[0];
    assign y_out     = res_reg[1];
    assign z_out     = res_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= in_valid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // Products, row sums, rounding with saturation
    always_comb
    begin
        for (int k = 0; k < 9; k++)
            prod_c[k] = $signed(matrix[k]) * vec_reg[k % 3];
        for (int r = 0; r < 3; r++)
        begin
            sum_c[r] = {{2{prod_reg[3*r][PROD_W-1]}},   prod_reg[3*r]}
                     + {{2{prod_reg[3*r+1][PROD_W-1]}}, prod_reg[3*r+1]}
                     + {{2{prod_reg[3*r+2][PROD_W-1]}}, prod_reg[3*r+2]};
        end
        rsum = '0;
        for (int r = 0; r < 3; r++)
        begin
            rsum     = sum_reg[r] + RND_HALF;
            rnd_c[r] = RND_W'(rsum >>> erv3_pkg::COEF_FRAC_BITS);
            if (rnd_c[r] > SAT_HI)
                res_c[r] = SAT_HI[OUT_W-1:0];
            else if (rnd_c[r] < SAT_LO)
                res_c[r] = SAT_LO[OUT_W-1:0];
            else
                res_c[r] = rnd_c[r][OUT_W-1:0];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (rdy0 && in_valid)
        begin
            vec_reg[0] <= x_in;
            vec_reg[1] <= y_in;
            vec_reg[2] <= z_in;
        end
        if (rdy1 && v0_reg)
            prod_reg <= prod_c;
        if (rdy2 && v1_reg)
            sum_reg <= sum_c;
        if (rdy3 && v2_reg)
            res_reg <= res_c;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/euler_rotate_vector3_top.sv =====
// ----------------------------------------------------------------------------
// euler_rotate_vector3_top
// Rotates streamed 3D points by R = Rz(roll) * Ry(pitch) * Rx(yaw), with
// angles set through the configuration channel.
// ----------------------------------------------------------------------------
// Points stream through a four-stage pipeline at one word per clock while
// m_tready and the matrix allow it; the rate is set by the nine parallel
// 18x18 multipliers of the product stage. Writing any angle register starts a
// matrix rebuild (one shared CORDIC at one iteration per cycle for three
// angles, then fifteen passes of one shared 32x32 multiplier); s_tready stays
// low until the new matrix is in place. After reset the matrix is the identity
// and points are taken at once. Write angles only while no point is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_rotate_vector3_top
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [erv3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [erv3_pkg::ANGLE_BITS-1:0] cfg_data,
    // input points
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    input  wire logic [55:0]                     s_tdata,  // x_in[17:0], y_in[35:18], z_in[53:36], zero pad
    // rotated points
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    output      logic [63:0]                     m_tdata   // x_out[18:0], y_out[37:19], z_out[56:38], zero pad
);

    localparam int CW = erv3_pkg::COORD_BITS;
    localparam int OW = erv3_pkg::OUT_W;

    erv3_pkg::matrix_t    matrix;
    erv3_pkg::rb_status_t rb_status;
    logic                 rb_busy;
    logic                 rot_in_ready;
    erv3_pkg::ocoord_t    x_out, y_out, z_out;

    erv3_rebuild u_rebuild
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .matrix    (matrix),
        .status    (rb_status)
    );

    // Hold off points while the matrix is stale or being rebuilt
    assign rb_busy  = rb_status.pending || rb_status.running;
    assign s_tready = rot_in_ready && !rb_busy;

    erv3_rotate u_rotate
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid && !rb_busy),
        .in_ready  (rot_in_ready),
        .x_in      (s_tdata[CW-1:0]),
        .y_in      (s_tdata[2*CW-1:CW]),
        .z_in      (s_tdata[3*CW-1:2*CW]),
        .matrix    (matrix),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .x_out     (x_out),
        .y_out     (y_out),
        .z_out     (z_out)
    );

    assign m_tdata = {{(64 - 3*OW){1'b0}}, z_out, y_out, x_out};

    // No point enters while a rebuild is due or running
    a_no_accept_in_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        rb_busy |-> !s_tready)
        else $error("point accepted during matrix rebuild");

    // An angle write always leads to a rebuild
    a_write_starts_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_index == erv3_pkg::REG_YAW
            || cfg_index == erv3_pkg::REG_PITCH || cfg_index == erv3_pkg::REG_ROLL))
        |=> (rb_status.pending || rb_status.running))
        else $error("angle write did not schedule a rebuild");

endmodule

`default_nettype wire

// ===== tb/tb_euler_rotate_vector3_top.sv =====
// ----------------------------------------------------------------------------
// tb_euler_rotate_vector3_top
// Self-checking bench for the Euler rotation block. A local bit-exact model
// (CORDIC sines and cosines, Q1.16 matrix, rounded and saturated products)
// predicts every rotated word. Angle sets go through quadrant edges, full
// scale and random values, and points run with random gaps and stalls on
// both streams, plus one long output hold that backs up the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_euler_rotate_vector3_top;

    import erv3_pkg::*;

    localparam int  CLK_PERIOD     = 10;
    localparam int  IDLE_LIMIT     = 2000;
    localparam int  RX_HOLD_CYCLES = 400;
    localparam int  TAIL_CYCLES    = 20;
    localparam int  RANDOM_POINTS  = 570;
    localparam int  FRAC_Q         = 30;
    localparam longint TRIG_GAIN   = 64'sd652032875;
    localparam int  ROTATE_STEPS   = (TRIG_ITERATIONS < 24) ? TRIG_ITERATIONS : 24;

    // index 3 decodes to no register
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quadrant_t;

    typedef struct {
        ocoord_t x;
        ocoord_t y;
        ocoord_t z;
    } rotated_t;

    // DUT ports
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ANGLE_BITS-1:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;   // x_in[17:0], y_in[35:18], z_in[53:36], zero pad
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;          // x_out[18:0], y_out[37:19], z_out[56:38], zero pad

    // model state
    logic [ANGLE_BITS-1:0] yaw_q, pitch_q, roll_q;
    longint                coef_mat [9];
    bit                    matrix_stale;
    rotated_t              rotated_points_q [$];

    int  err_count       = 0;
    int  idle_cycles     = 0;
    bit  tx_gaps_on      = 1'b0;
    bit  rx_stalls_on    = 1'b0;
    bit  rx_hold_request = 1'b0;

    euler_rotate_vector3_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Fixed-point model
    // ------------------------------------------------------------------------

    function automatic longint round_up_shift(input longint v, input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp_bits(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // arctan(2^-i) in 32-bit turn units
    function automatic longint atan_step(input int i);
        case (i)
            0:       return 64'h20000000;
            1:       return 64'h12E4051E;
            2:       return 64'h09FB385B;
            3:       return 64'h051111D4;
            4:       return 64'h028B0D43;
            5:       return 64'h0145D7E1;
            6:       return 64'h00A2F61E;
            7:       return 64'h00517C55;
            8:       return 64'h0028BE53;
            9:       return 64'h00145F2F;
            10:      return 64'h000A2F98;
            11:      return 64'h000517CC;
            12:      return 64'h00028BE6;
            13:      return 64'h000145F3;
            14:      return 64'h0000A2F9;
            15:      return 64'h0000517C;
            16:      return 64'h000028BE;
            17:      return 64'h0000145F;
            18:      return 64'h00000A2F;
            19:      return 64'h00000517;
            20:      return 64'h0000028B;
            21:      return 64'h00000145;
            22:      return 64'h000000A2;
            default: return 64'h00000051;
        endcase
    endfunction

    // Q30 cosine and sine of an angle; CORDIC on the in-quadrant part
    function automatic void angle_trig(input logic [ANGLE_BITS-1:0] ang,
                                       output longint c, output longint s);
        logic [31:0] turn;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        turn = {ang, {(32-ANGLE_BITS){1'b0}}};
        x = TRIG_GAIN;
        y = 0;
        z = turn[29:0];
        for (int i = 0; i < ROTATE_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step(i);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step(i);
            end
        end
        case (quadrant_t'(turn[31:30]))
            QUAD_I:   begin c = x;  s = y;  end
            QUAD_II:  begin c = -y; s = x;  end
            QUAD_III: begin c = -x; s = -y; end
            default:  begin c = y;  s = -x; end
        endcase
    endfunction

    function automatic longint to_coef(input longint q60);
        return clamp_bits(round_up_shift(q60, 2 * FRAC_Q - COEF_FRAC_BITS), COEF_W);
    endfunction

    // R = Rz(roll) * Ry(pitch) * Rx(yaw)
    function automatic void build_matrix();
        longint ca, sa, cb, sb, cg, sg, casb, sasb;
        angle_trig(roll_q, ca, sa);
        angle_trig(pitch_q, cb, sb);
        angle_trig(yaw_q, cg, sg);
        casb = round_up_shift(ca * sb, FRAC_Q);
        sasb = round_up_shift(sa * sb, FRAC_Q);
        coef_mat[0] = to_coef(ca * cb);
        coef_mat[1] = to_coef(casb * sg - sa * cg);
        coef_mat[2] = to_coef(casb * cg + sa * sg);
        coef_mat[3] = to_coef(sa * cb);
        coef_mat[4] = to_coef(sasb * sg + ca * cg);
        coef_mat[5] = to_coef(sasb * cg - ca * sg);
        coef_mat[6] = to_coef(-sb * (64'sd1 <<< FRAC_Q));
        coef_mat[7] = to_coef(cb * sg);
        coef_mat[8] = to_coef(cb * cg);
    endfunction

    function automatic void reset_model();
        yaw_q   = '0;
        pitch_q = '0;
        roll_q  = '0;
        for (int k = 0; k < 9; k++)
            coef_mat[k] = (k % 4 == 0) ? (64'sd1 <<< COEF_FRAC_BITS) : 0;
        matrix_stale = 1'b0;
    endfunction

    function automatic void note_register_write(input logic [CFG_IDX_W-1:0] idx,
                                                input logic [ANGLE_BITS-1:0] val);
        case (idx)
            REG_YAW:   begin yaw_q   = val; matrix_stale = 1'b1; end
            REG_PITCH: begin pitch_q = val; matrix_stale = 1'b1; end
            REG_ROLL:  begin roll_q  = val; matrix_stale = 1'b1; end
            default:   ;
        endcase
    endfunction

    function automatic rotated_t rotate_point(input logic [55:0] word);
        longint   v [3];
        longint   acc;
        rotated_t r;
        if (matrix_stale)
        begin
            build_matrix();
            matrix_stale = 1'b0;
        end
        v[0] = coord_t'(word[17:0]);
        v[1] = coord_t'(word[35:18]);
        v[2] = coord_t'(word[53:36]);
        for (int row = 0; row < 3; row++)
        begin
            acc = coef_mat[3*row] * v[0] + coef_mat[3*row+1] * v[1]
                + coef_mat[3*row+2] * v[2];
            acc = clamp_bits(round_up_shift(acc, COEF_FRAC_BITS), OUT_W);
            case (row)
                0:       r.x = ocoord_t'(acc);
                1:       r.y = ocoord_t'(acc);
                default: r.z = ocoord_t'(acc);
            endcase
        end
        return r;
    endfunction

    task automatic check_rotated(input logic [63:0] word);
        rotated_t got;
        rotated_t want;
        got.x = word[18:0];
        got.y = word[37:19];
        got.z = word[56:38];
        if (rotated_points_q.size() == 0)
        begin
            $error("unexpected word: x_out=%0d y_out=%0d z_out=%0d", got.x, got.y, got.z);
            err_count++;
        end
        else
        begin
            want = rotated_points_q.pop_front();
            if (got.x !== want.x)
            begin
                $error("x_out: expected %0d, actual %0d", want.x, got.x);
                err_count++;
            end
            if (got.y !== want.y)
            begin
                $error("y_out: expected %0d, actual %0d", want.y, got.y);
                err_count++;
            end
            if (got.z !== want.z)
            begin
                $error("z_out: expected %0d, actual %0d", want.z, got.z);
                err_count++;
            end
        end
    endtask

    // Track every handshake: register writes, points in, points out
    initial reset_model();

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                note_register_write(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                rotated_points_q.push_back(rotate_point(s_tdata));
            if (m_tvalid && m_tready)
                check_rotated(m_tdata);
        end
    end

    // Watchdog: cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_euler_rotate_vector3_top NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 11))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            3:       return '1;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic logic [ANGLE_BITS-1:0] pick_angle();
        logic [ANGLE_BITS-1:0] edge_ang;
        edge_ang = {2'($urandom_range(0, 3)), {(ANGLE_BITS-2){1'b0}}};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return edge_ang;
            3:       return edge_ang + 1'b1;
            4:       return edge_ang - 1'b1;
            default: return ANGLE_BITS'($urandom);
        endcase
    endfunction

    // Output side: random stalls, or one long hold on request
    initial
    begin : sink
        int pause;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (rx_hold_request)
            begin
                rx_hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_stalls_on && $urandom_range(0, 2) == 0)
            begin
                pause = pick_gap();
                if (pause == 0)
                    pause = 1;
                m_tready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // one register write; cfg_valid stays up for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [ANGLE_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_angles(input logic [ANGLE_BITS-1:0] yaw,
                              input logic [ANGLE_BITS-1:0] pitch,
                              input logic [ANGLE_BITS-1:0] roll);
        write_reg(REG_YAW, yaw);
        write_reg(REG_PITCH, pitch);
        write_reg(REG_ROLL, roll);
        cfg_valid <= 1'b0;
    endtask

    // offer one point, after an optional gap, and wait for the accept
    task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 56'({$urandom, $urandom});
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, z, y, x};
        do @(posedge clk); while (!s_tready);
    endtask

    // drop s_tvalid and let the last accepted point be queued before waiting
    task automatic drain_points();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (rotated_points_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset matrix is the identity: points come back unchanged
    task automatic test_identity_passthrough();
        send_point(COORD_MAX, COORD_MIN, '0);
        send_point(COORD_MIN, COORD_MAX, '1);
        send_point(coord_t'(18'h15555), coord_t'(18'h2AAAA), COORD_MAX);
        send_point('1, '0, COORD_MIN);
        drain_points();
    endtask

    // a write to the unused index leaves the matrix alone
    task automatic test_unused_register();
        write_reg(REG_UNUSED, '1);
        cfg_valid <= 1'b0;
        send_point(coord_t'(18'h2AAAA), coord_t'(18'h15555), coord_t'(18'h00100));
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        drain_points();
    endtask

    // one axis at a time, on quadrant boundaries
    task automatic test_quadrant_angles();
        set_angles(16'h4000, 16'h0000, 16'h0000);
        send_point(COORD_MAX, COORD_MIN, coord_t'(18'h01000));
        send_point(coord_t'(18'h00100), COORD_MAX, COORD_MIN);
        drain_points();
        set_angles(16'h0000, 16'h8000, 16'h0000);
        send_point(COORD_MIN, coord_t'(18'h00100), COORD_MAX);
        send_point(COORD_MAX, COORD_MAX, '1);
        drain_points();
        set_angles(16'h0000, 16'h0000, 16'hC000);
        send_point(COORD_MAX, coord_t'(18'h3FF00), COORD_MIN);
        send_point('1, COORD_MIN, COORD_MAX);
        drain_points();
    endtask

    // all three axes, full scale and mixed octants
    task automatic test_full_scale_angles();
        set_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        drain_points();
        set_angles(16'h2000, 16'h2000, 16'h2000);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MAX, COORD_MIN);
        drain_points();
        set_angles(16'h6000, 16'hA000, 16'hE000);
        send_point(COORD_MIN, COORD_MIN, COORD_MAX);
        send_point(coord_t'(18'h12345), coord_t'(18'h2ABCD), coord_t'(18'h00001));
        drain_points();
    endtask

    // phases of random angle writes and random points with random idling
    task automatic test_random_phases();
        int sent;
        int burst;
        bit wrote;
        sent = 0;
        while (sent < RANDOM_POINTS)
        begin
            wrote = 1'b0;
            if ($urandom_range(0, 2) != 0)
            begin
                write_reg(REG_YAW, pick_angle());
                wrote = 1'b1;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                write_reg(REG_PITCH, pick_angle());
                wrote = 1'b1;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                write_reg(REG_ROLL, pick_angle());
                wrote = 1'b1;
            end
            if ($urandom_range(0, 7) == 0)
            begin
                write_reg(REG_UNUSED, ANGLE_BITS'($urandom));
                wrote = 1'b1;
            end
            if (wrote)
                cfg_valid <= 1'b0;
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            burst = $urandom_range(5, 60);
            repeat (burst)
            begin
                send_point(pick_coord(), pick_coord(), pick_coord());
                sent++;
            end
            drain_points();
        end
    endtask

    // long output hold with a steady input stream: pipeline fills and stalls
    task automatic test_output_backpressure();
        set_angles(pick_angle(), pick_angle(), pick_angle());
        tx_gaps_on      = 1'b0;
        rx_stalls_on    = 1'b0;
        rx_hold_request = 1'b1;
        repeat (40)
            send_point(pick_coord(), pick_coord(), pick_coord());
        drain_points();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_identity_passthrough();
        test_unused_register();
        test_quadrant_angles();
        test_full_scale_angles();
        test_random_phases();
        test_output_backpressure();

        // let any stray word show up before the verdict
        drain_points();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb_euler_rotate_vector3_top OK");
        else
            $display("tb_euler_rotate_vector3_top NOT OK");
        $finish;
    end

endmodule
